@@ sv/ocp_pkg.sv @@
// Shared types, codes and saturating arithmetic for the OFDM cyclic prefix and preamble inserter.
// No dependencies; the top level, ocp_front and ocp_back import this package.
package ocp_pkg;

   localparam int FFT_SIZE_DEF     = 64;
   localparam int CP_LEN_DEF       = 16;
   localparam int PREAMBLE_LEN_DEF = 320;
   localparam int TAIL_LEN_DEF     = 16;
   localparam int QUEUE_DEPTH      = 4;

   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_PUSH = 2'd1;
   localparam logic [1:0] REQ_PULL = 2'd2;

   localparam logic [1:0] ST_ACCEPTED  = 2'd0;
   localparam logic [1:0] ST_SAMPLE    = 2'd1;
   localparam logic [1:0] ST_NOT_READY = 2'd2;
   localparam logic [1:0] ST_REJECTED  = 2'd3;

   // Work left for the back end after a request has been classified.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_PUSH,
      OP_PRE,
      OP_SYM,
      OP_OVL_PRE,
      OP_OVL_SYM
   } op_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [8:0]         entry_index;
      logic signed [15:0] sample_i;
      logic signed [15:0] sample_q;
      logic               frame_end;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [15:0] out_i;
      logic signed [15:0] out_q;
      logic               frame_last;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]         status;
      op_type             op;
      logic               last;
      logic signed [15:0] data_i;
      logic signed [15:0] data_q;
   } cmd_type;

   function automatic logic signed [15:0] half16(input logic signed [15:0] v);
      return v >>> 1;
   endfunction

   function automatic logic signed [15:0] add_sat(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
      logic signed [16:0] s;
      s = {a[15], a} + {b[15], b};
      if (s[16] != s[15]) begin
         return s[16] ? 16'sh8000 : 16'sh7fff;
      end
      return s[15:0];
   endfunction

endpackage

@@ sv/ofdm_cyclic_prefix_preamble_inserter.sv @@
// OFDM transmit framer: preamble, cyclic prefix, overlap samples between symbols and a tail.
// Top level; depends on ocp_pkg, ocp_front, ocp_queue and ocp_back.
//
// Every request word on req_* (load preamble entry, push symbol sample, pull next frame
// sample) yields exactly one response word on rsp_*, in order. The status field tells
// accepted, sample given, not ready, or push rejected because both symbol slots are full
// or the frame end was already pushed. Throughput is one request word per clock while
// req_stall is low. An accepted request word is written into the queue, and the back end
// pops it and registers the memory read in its output register, which drives rsp_*.
// The front end decides each word's outcome from its counters alone; the back end does the
// memory access and the halving and saturating add. A four-entry queue sits between them.
// When rsp_stall is high the output register holds its word, the queue fills, and req_stall
// rises once the queue is full; nothing is dropped.
// Synchronous reset clears the sequencing state and all valid flags; the frame restarts at
// preamble sample 0. The preamble and symbol memories are not cleared and read as
// whatever they held until written.
module ofdm_cyclic_prefix_preamble_inserter #(
   parameter int FFT_SIZE     = ocp_pkg::FFT_SIZE_DEF,
   parameter int CP_LEN       = ocp_pkg::CP_LEN_DEF,
   parameter int PREAMBLE_LEN = ocp_pkg::PREAMBLE_LEN_DEF,
   parameter int TAIL_LEN     = ocp_pkg::TAIL_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ocp_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ocp_pkg::rsp_word_type rsp_word
);
   import ocp_pkg::*;

   localparam int PRE_AW = (PREAMBLE_LEN > 1) ? $clog2(PREAMBLE_LEN) : 1;
   localparam int SYM_AW = $clog2(2 * FFT_SIZE);
   localparam int CMD_W  = $bits(cmd_type);
   localparam int Q_W    = CMD_W + PRE_AW + 2 * SYM_AW;

   cmd_type           f_cmd, b_cmd;
   logic [PRE_AW-1:0] f_pre_addr, b_pre_addr;
   logic [SYM_AW-1:0] f_sym_a, f_sym_b, b_sym_a, b_sym_b;
   logic              q_push, q_pop, q_full, q_empty;
   logic [Q_W-1:0]    q_in, q_out;

   ocp_front #(
      .FFT_SIZE    (FFT_SIZE),
      .CP_LEN      (CP_LEN),
      .PREAMBLE_LEN(PREAMBLE_LEN),
      .TAIL_LEN    (TAIL_LEN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .q_full   (q_full),
      .q_push   (q_push),
      .cmd      (f_cmd),
      .pre_addr (f_pre_addr),
      .sym_a    (f_sym_a),
      .sym_b    (f_sym_b)
   );

   assign q_in = {f_cmd, f_pre_addr, f_sym_a, f_sym_b};

   ocp_queue #(
      .WIDTH(Q_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_in),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_out),
      .empty    (q_empty)
   );

   assign b_cmd      = cmd_type'(q_out[Q_W-1 -: CMD_W]);
   assign b_pre_addr = q_out[2 * SYM_AW +: PRE_AW];
   assign b_sym_a    = q_out[SYM_AW +: SYM_AW];
   assign b_sym_b    = q_out[0 +: SYM_AW];

   ocp_back #(
      .FFT_SIZE    (FFT_SIZE),
      .PREAMBLE_LEN(PREAMBLE_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_cmd     (b_cmd),
      .q_pre_addr(b_pre_addr),
      .q_sym_a   (b_sym_a),
      .q_sym_b   (b_sym_b),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // An accepted word is held in the queue until the back end takes it.
   a_accept_queued: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !q_empty)
      else $error("accepted request word did not reach the command queue");

   // With nothing queued and nothing shown, no response word can appear next cycle.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      q_empty && !rsp_valid |=> !rsp_valid)
      else $error("response word appeared without a queued command");

   // The frame end flag only ever rides on a delivered sample.
   a_last_is_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.frame_last |-> rsp_word.status == ST_SAMPLE)
      else $error("frame_last set on a word that carries no sample");

endmodule

@@ sv/ocp_queue.sv @@
// Small first-in first-out queue of classified commands between front and back end.
// Generic width; depth comes from the top level.
module ocp_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTRW-1:0]  head_ff, head_in;
   logic [PTRW-1:0]  tail_ff, tail_in;
   logic [CNTW-1:0]  count_ff, count_in;

   function automatic logic [PTRW-1:0] ptr_inc(input logic [PTRW-1:0] p);
      return (p == PTRW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full     = (count_ff == CNTW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[head_ff];

   always_comb begin
      head_in  = pop ? ptr_inc(head_ff) : head_ff;
      tail_in  = push ? ptr_inc(tail_ff) : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

endmodule

@@ sv/ocp_front.sv @@
// Front end: accepts request words, keeps the frame sequencing state and turns each request
// into a status and a memory command for the back end. Depends on ocp_pkg.
module ocp_front #(
   parameter int FFT_SIZE     = ocp_pkg::FFT_SIZE_DEF,
   parameter int CP_LEN       = ocp_pkg::CP_LEN_DEF,
   parameter int PREAMBLE_LEN = ocp_pkg::PREAMBLE_LEN_DEF,
   parameter int TAIL_LEN     = ocp_pkg::TAIL_LEN_DEF,
   localparam int PRE_AW = (PREAMBLE_LEN > 1) ? $clog2(PREAMBLE_LEN) : 1,
   localparam int SYM_AW = $clog2(2 * FFT_SIZE)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ocp_pkg::req_word_type req_word,
   input  logic                 q_full,
   output logic                 q_push,
   output ocp_pkg::cmd_type     cmd,
   output logic [PRE_AW-1:0]    pre_addr,
   output logic [SYM_AW-1:0]    sym_a,
   output logic [SYM_AW-1:0]    sym_b
);
   import ocp_pkg::*;

   localparam int KW        = $clog2(FFT_SIZE);
   localparam int RP_MAX_A  = (PREAMBLE_LEN > CP_LEN + FFT_SIZE) ? PREAMBLE_LEN
                                                                 : CP_LEN + FFT_SIZE;
   localparam int RP_MAX    = (RP_MAX_A > TAIL_LEN) ? RP_MAX_A : TAIL_LEN;
   localparam int RPW       = $clog2(RP_MAX + 1);
   localparam int CP_BASE   = (FFT_SIZE - (CP_LEN % FFT_SIZE)) % FFT_SIZE;
   localparam int CP_NEXT   = (CP_BASE + 1) % FFT_SIZE;
   localparam int TAIL_BASE = (FFT_SIZE - (TAIL_LEN % FFT_SIZE)) % FFT_SIZE;
   localparam int TAIL_NEXT = (TAIL_BASE + 1) % FFT_SIZE;

   localparam logic [1:0] PH_PRE  = 2'd0;
   localparam logic [1:0] PH_SYM  = 2'd1;
   localparam logic [1:0] PH_TAIL = 2'd2;

   logic [KW-1:0]  wk_ff, wk_in;
   logic           wslot_ff, wslot_in;
   logic [1:0]     phase_ff, phase_in;
   logic [RPW-1:0] rp_ff, rp_in;
   logic [KW-1:0]  rk_ff, rk_in;
   logic [1:0]     held_ff, held_in;
   logic           end_ff, end_in;
   logic           accept;
   logic           rs;

   function automatic logic [SYM_AW-1:0] sym_addr(input logic slot, input logic [KW-1:0] k);
      return slot ? SYM_AW'(FFT_SIZE) + SYM_AW'(k) : SYM_AW'(k);
   endfunction

   function automatic logic [KW-1:0] k_inc(input logic [KW-1:0] k);
      return (k == KW'(FFT_SIZE - 1)) ? '0 : k + 1'b1;
   endfunction

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;

   // With both slots full the oldest symbol sits where the writer will go next.
   assign rs = (held_ff >= 2'd2) ? wslot_ff : !wslot_ff;

   always_comb begin
      wk_in      = wk_ff;
      wslot_in   = wslot_ff;
      phase_in   = phase_ff;
      rp_in      = rp_ff;
      rk_in      = rk_ff;
      held_in    = held_ff;
      end_in     = end_ff;
      cmd.status = ST_NOT_READY;
      cmd.op     = OP_NONE;
      cmd.last   = 1'b0;
      cmd.data_i = req_word.sample_i;
      cmd.data_q = req_word.sample_q;
      pre_addr   = '0;
      sym_a      = '0;
      sym_b      = '0;

      case (req_word.req_type)
         REQ_LOAD: begin
            cmd.status = ST_ACCEPTED;
            if (int'(req_word.entry_index) < PREAMBLE_LEN) begin
               cmd.op   = OP_LOAD;
               pre_addr = PRE_AW'(req_word.entry_index);
            end
         end
         REQ_PUSH: begin
            if (held_ff >= 2'd2 || end_ff) begin
               cmd.status = ST_REJECTED;
            end else begin
               cmd.status = ST_ACCEPTED;
               cmd.op     = OP_PUSH;
               sym_a      = sym_addr(wslot_ff, wk_ff);
               if (wk_ff == KW'(FFT_SIZE - 1)) begin
                  wk_in    = '0;
                  wslot_in = !wslot_ff;
                  held_in  = held_ff + 2'd1;
                  end_in   = end_ff | req_word.frame_end;
               end else begin
                  wk_in = wk_ff + 1'b1;
               end
            end
         end
         REQ_PULL: begin
            case (phase_ff)
               PH_PRE: begin
                  if (rp_ff < RPW'(PREAMBLE_LEN - 1)) begin
                     cmd.status = ST_SAMPLE;
                     cmd.op     = OP_PRE;
                     pre_addr   = PRE_AW'(rp_ff);
                     rp_in      = rp_ff + 1'b1;
                  end else if (held_ff >= 2'd1) begin
                     // The last preamble sample is overlapped with the first prefix sample.
                     cmd.status = ST_SAMPLE;
                     cmd.op     = OP_OVL_PRE;
                     pre_addr   = PRE_AW'(PREAMBLE_LEN - 1);
                     sym_a      = sym_addr(rs, KW'(CP_BASE));
                     phase_in   = PH_SYM;
                     rp_in      = RPW'(1);
                     rk_in      = KW'(CP_NEXT);
                  end
               end
               PH_SYM: begin
                  if (rp_ff < RPW'(CP_LEN)) begin
                     cmd.status = ST_SAMPLE;
                     cmd.op     = OP_SYM;
                     sym_a      = sym_addr(rs, rk_ff);
                     rp_in      = rp_ff + 1'b1;
                     rk_in      = (rp_ff == RPW'(CP_LEN - 1)) ? '0 : k_inc(rk_ff);
                  end else if (rp_ff < RPW'(CP_LEN + FFT_SIZE)) begin
                     cmd.status = ST_SAMPLE;
                     cmd.op     = OP_SYM;
                     sym_a      = sym_addr(rs, rk_ff);
                     rp_in      = rp_ff + 1'b1;
                     rk_in      = k_inc(rk_ff);
                  end else if (held_ff >= 2'd2) begin
                     cmd.status = ST_SAMPLE;
                     cmd.op     = OP_OVL_SYM;
                     sym_a      = sym_addr(rs, KW'(CP_BASE));
                     sym_b      = sym_addr(!rs, KW'(CP_BASE));
                     held_in    = held_ff - 2'd1;
                     rp_in      = RPW'(1);
                     rk_in      = KW'(CP_NEXT);
                  end else if (held_ff == 2'd1 && end_ff) begin
                     cmd.status = ST_SAMPLE;
                     if (CP_LEN == TAIL_LEN) begin
                        cmd.op = OP_SYM;
                        sym_a  = sym_addr(rs, KW'(TAIL_BASE));
                     end else begin
                        cmd.op = OP_OVL_SYM;
                        sym_a  = sym_addr(rs, KW'(CP_BASE));
                        sym_b  = sym_addr(rs, KW'(TAIL_BASE));
                     end
                     phase_in = PH_TAIL;
                     rp_in    = RPW'(1);
                     rk_in    = KW'(TAIL_NEXT);
                  end
               end
               PH_TAIL: begin
                  cmd.status = ST_SAMPLE;
                  cmd.op     = OP_SYM;
                  sym_a      = sym_addr(rs, rk_ff);
                  if (rp_ff >= RPW'(TAIL_LEN - 1)) begin
                     cmd.last = 1'b1;
                     held_in  = (held_ff != 2'd0) ? held_ff - 2'd1 : 2'd0;
                     end_in   = 1'b0;
                     phase_in = PH_PRE;
                     rp_in    = '0;
                  end else begin
                     rp_in = rp_ff + 1'b1;
                     rk_in = k_inc(rk_ff);
                  end
               end
               default: begin
                  phase_in = PH_PRE;
               end
            endcase
         end
         default: begin
            cmd.status = ST_NOT_READY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wk_ff    <= '0;
         wslot_ff <= 1'b0;
         phase_ff <= PH_PRE;
         rp_ff    <= '0;
         rk_ff    <= '0;
         held_ff  <= 2'd0;
         end_ff   <= 1'b0;
      end else if (accept) begin
         wk_ff    <= wk_in;
         wslot_ff <= wslot_in;
         phase_ff <= phase_in;
         rp_ff    <= rp_in;
         rk_ff    <= rk_in;
         held_ff  <= held_in;
         end_ff   <= end_in;
      end
   end

endmodule

@@ sv/ocp_back.sv @@
// Back end: holds the preamble and symbol memories, carries out queued commands and
// forms the result word in an output register. Depends on ocp_pkg.
module ocp_back #(
   parameter int FFT_SIZE     = ocp_pkg::FFT_SIZE_DEF,
   parameter int PREAMBLE_LEN = ocp_pkg::PREAMBLE_LEN_DEF,
   localparam int PRE_AW = (PREAMBLE_LEN > 1) ? $clog2(PREAMBLE_LEN) : 1,
   localparam int SYM_AW = $clog2(2 * FFT_SIZE)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  ocp_pkg::cmd_type      q_cmd,
   input  logic [PRE_AW-1:0]     q_pre_addr,
   input  logic [SYM_AW-1:0]     q_sym_a,
   input  logic [SYM_AW-1:0]     q_sym_b,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ocp_pkg::rsp_word_type rsp_word
);
   import ocp_pkg::*;

   logic [31:0] pre_mem [PREAMBLE_LEN];
   logic [31:0] sym_mem [2 * FFT_SIZE];

   logic        valid_ff, valid_in;
   cmd_type     cmd_ff;
   logic [31:0] pre_rd_ff;
   logic [31:0] a_rd_ff;
   logic [31:0] b_rd_ff;
   logic        advance;
   logic signed [15:0] val_i, val_q;

   assign advance  = !valid_ff || !rsp_stall;
   assign q_pop    = advance && !q_empty;
   assign valid_in = advance ? !q_empty : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Loads and pushes never share a cycle with a pull, so read and write do not collide.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         if (q_cmd.op == OP_LOAD) begin
            pre_mem[q_pre_addr] <= {q_cmd.data_i, q_cmd.data_q};
         end
         if (q_cmd.op == OP_PUSH) begin
            sym_mem[q_sym_a] <= {q_cmd.data_i, q_cmd.data_q};
         end
         pre_rd_ff <= pre_mem[q_pre_addr];
         a_rd_ff   <= sym_mem[q_sym_a];
         b_rd_ff   <= sym_mem[q_sym_b];
         cmd_ff    <= q_cmd;
      end
   end

   always_comb begin
      case (cmd_ff.op)
         OP_PRE: begin
            val_i = pre_rd_ff[31:16];
            val_q = pre_rd_ff[15:0];
         end
         OP_SYM: begin
            val_i = a_rd_ff[31:16];
            val_q = a_rd_ff[15:0];
         end
         OP_OVL_PRE: begin
            val_i = add_sat(pre_rd_ff[31:16], half16(a_rd_ff[31:16]));
            val_q = add_sat(pre_rd_ff[15:0], half16(a_rd_ff[15:0]));
         end
         OP_OVL_SYM: begin
            val_i = add_sat(half16(a_rd_ff[31:16]), half16(b_rd_ff[31:16]));
            val_q = add_sat(half16(a_rd_ff[15:0]), half16(b_rd_ff[15:0]));
         end
         default: begin
            val_i = '0;
            val_q = '0;
         end
      endcase
   end

   assign rsp_valid           = valid_ff;
   assign rsp_word.status     = cmd_ff.status;
   assign rsp_word.out_i      = (cmd_ff.status == ST_SAMPLE) ? val_i : '0;
   assign rsp_word.out_q      = (cmd_ff.status == ST_SAMPLE) ? val_q : '0;
   assign rsp_word.frame_last = cmd_ff.last;

endmodule
